// ----- sv/sws_pkg.sv -----
`timescale 1ns / 1ps

package sws_pkg;

   localparam int PHASE_BITS_DEF     = 32;
   localparam int SINE_FRAC_BITS_DEF = 15;

   localparam int TIME_BITS      = 48;
   localparam int TIME_HALF_BITS = 24;
   localparam int STEP_BITS      = 32;
   localparam int PROD_BITS      = TIME_HALF_BITS + STEP_BITS;
   localparam int ANGLE_BITS     = 32;
   localparam int AMP_BITS       = 24;
   localparam int OFFSET_BITS    = 32;
   localparam int OUT_BITS       = 32;
   localparam int SUM_BITS       = OUT_BITS + 2;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_PHASE_STEP     = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVE_AMPLITUDE = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WAVE_OFFSET    = 2'd2;

   localparam int CORDIC_STEPS = 30;
   localparam int CORDIC_WIDTH = 33;

   typedef logic signed [CORDIC_WIDTH-1:0] cordic_type;

   localparam cordic_type CORDIC_GAIN = 33'sd652032874;

   typedef struct packed {
      logic       valid;
      cordic_type x;
      cordic_type y;
      cordic_type z;
   } cordic_word_type;

   function automatic cordic_type atan_value(input int step);
      cordic_type result;
      case (step)
         0:       result = 33'sd536870912;
         1:       result = 33'sd316933406;
         2:       result = 33'sd167458907;
         3:       result = 33'sd85004756;
         4:       result = 33'sd42667331;
         5:       result = 33'sd21354465;
         6:       result = 33'sd10679838;
         7:       result = 33'sd5340245;
         8:       result = 33'sd2670163;
         9:       result = 33'sd1335087;
         10:      result = 33'sd667544;
         11:      result = 33'sd333772;
         12:      result = 33'sd166886;
         13:      result = 33'sd83443;
         14:      result = 33'sd41722;
         15:      result = 33'sd20861;
         16:      result = 33'sd10430;
         17:      result = 33'sd5215;
         18:      result = 33'sd2608;
         19:      result = 33'sd1304;
         20:      result = 33'sd652;
         21:      result = 33'sd326;
         22:      result = 33'sd163;
         23:      result = 33'sd81;
         24:      result = 33'sd41;
         25:      result = 33'sd20;
         26:      result = 33'sd10;
         27:      result = 33'sd5;
         28:      result = 33'sd3;
         29:      result = 33'sd1;
         default: result = '0;
      endcase
      return result;
   endfunction

endpackage

// ----- sv/sws_phase.sv -----
`timescale 1ns / 1ps

module sws_phase
   import sws_pkg::*;
#(
   parameter int PHASE_BITS = PHASE_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic                  in_valid,
   input  logic [TIME_BITS-1:0]  time_us,
   input  logic [STEP_BITS-1:0]  phase_step,
   output cordic_word_type       word_out
);

   localparam cordic_type HALF_TURN    = 33'sh0_8000_0000;
   localparam cordic_type QUARTER_TURN = 33'sh0_4000_0000;

   logic                   prod_valid_ff;
   logic [PROD_BITS-1:0]   prod_lo_ff, prod_lo_in;
   logic [PROD_BITS-1:0]   prod_hi_ff, prod_hi_in;

   logic                   angle_valid_ff;
   logic [ANGLE_BITS-1:0]  angle_ff, angle_in;
   logic [PROD_BITS+TIME_HALF_BITS-1:0] hi_shifted;
   logic [PHASE_BITS-1:0]  phase_sum;
   logic [PHASE_BITS+ANGLE_BITS-1:0] phase_ext;

   logic                   fold_valid_ff;
   cordic_type             fold_z_ff, fold_z_in;
   cordic_type             angle_s;

   // split 48 x 32 product into two 24 x 32 partial products
   assign prod_lo_in = PROD_BITS'(time_us[TIME_HALF_BITS-1:0]) * PROD_BITS'(phase_step);
   assign prod_hi_in = PROD_BITS'(time_us[TIME_BITS-1:TIME_HALF_BITS]) *
                       PROD_BITS'(phase_step);

   assign hi_shifted = {prod_hi_ff, {TIME_HALF_BITS{1'b0}}};
   assign phase_sum  = prod_lo_ff[PHASE_BITS-1:0] + hi_shifted[PHASE_BITS-1:0];
   assign phase_ext  = {phase_sum, {ANGLE_BITS{1'b0}}};
   assign angle_in   = phase_ext[PHASE_BITS+ANGLE_BITS-1 -: ANGLE_BITS];

   // fold angle into [-quarter, quarter]
   assign angle_s = cordic_type'(signed'(angle_ff));
   always_comb begin
      if (angle_s > QUARTER_TURN) begin
         fold_z_in = HALF_TURN - angle_s;
      end else if (angle_s < -QUARTER_TURN) begin
         fold_z_in = -HALF_TURN - angle_s;
      end else begin
         fold_z_in = angle_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff  <= 1'b0;
         angle_valid_ff <= 1'b0;
         fold_valid_ff  <= 1'b0;
      end else if (advance) begin
         prod_valid_ff  <= in_valid;
         angle_valid_ff <= prod_valid_ff;
         fold_valid_ff  <= angle_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_lo_ff <= prod_lo_in;
         prod_hi_ff <= prod_hi_in;
         angle_ff   <= angle_in;
         fold_z_ff  <= fold_z_in;
      end
   end

   assign word_out.valid = fold_valid_ff;
   assign word_out.x     = CORDIC_GAIN;
   assign word_out.y     = '0;
   assign word_out.z     = fold_z_ff;

endmodule

// ----- sv/sws_cordic_cell.sv -----
`timescale 1ns / 1ps

module sws_cordic_cell
   import sws_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  cordic_word_type cell_in,
   output cordic_word_type cell_out
);

   localparam cordic_type ATAN = atan_value(STAGE);

   logic       valid_ff;
   cordic_type x_ff, x_in;
   cordic_type y_ff, y_in;
   cordic_type z_ff, z_in;
   cordic_type x_shift, y_shift;

   assign x_shift = cordic_type'(cell_in.x) >>> STAGE;
   assign y_shift = cordic_type'(cell_in.y) >>> STAGE;

   always_comb begin
      if (!cell_in.z[CORDIC_WIDTH-1]) begin
         x_in = cell_in.x - y_shift;
         y_in = cell_in.y + x_shift;
         z_in = cell_in.z - ATAN;
      end else begin
         x_in = cell_in.x + y_shift;
         y_in = cell_in.y - x_shift;
         z_in = cell_in.z + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign cell_out.valid = valid_ff;
   assign cell_out.x     = x_ff;
   assign cell_out.y     = y_ff;
   assign cell_out.z     = z_ff;

endmodule

// ----- sv/sws_scale.sv -----
`timescale 1ns / 1ps

module sws_scale
   import sws_pkg::*;
#(
   parameter int SINE_FRAC_BITS = SINE_FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  cordic_word_type               word_in,
   input  logic signed [AMP_BITS-1:0]    wave_amplitude,
   input  logic signed [OFFSET_BITS-1:0] wave_offset,
   output logic                          out_valid,
   output logic signed [OUT_BITS-1:0]    sample_value,
   output logic                          saturated
);

   localparam int F  = SINE_FRAC_BITS;
   localparam int SW = F + 1;
   localparam int YW = CORDIC_WIDTH + 1;
   localparam int PW = AMP_BITS + SW;
   localparam int MW = PW + 1 - F;

   localparam logic signed [YW-1:0]       Y_ROUND  = YW'(1) <<< (29 - F);
   localparam logic signed [YW-1:0]       S_MAX    = (YW'(1) <<< F) - YW'(1);
   localparam logic signed [YW-1:0]       S_MIN    = -(YW'(1) <<< F);
   localparam logic signed [PW:0]         M_ROUND  = (PW+1)'(1) <<< (F - 1);
   localparam logic signed [SUM_BITS-1:0] OUT_MAX  = SUM_BITS'(33'sh0_7FFF_FFFF);
   localparam logic signed [SUM_BITS-1:0] OUT_MIN  = -SUM_BITS'(33'sh0_8000_0000);

   logic                       sine_valid_ff;
   logic signed [SW-1:0]       sine_ff, sine_in;
   logic signed [YW-1:0]       y_round, y_quot;

   logic                       prod_valid_ff;
   logic signed [PW-1:0]       prod_ff, prod_in;

   logic                       m_valid_ff;
   logic signed [MW-1:0]       m_ff, m_in;
   logic signed [PW:0]         prod_round;

   logic                       out_valid_ff;
   logic signed [OUT_BITS-1:0] sample_ff, sample_in;
   logic                       sat_ff, sat_in;
   logic signed [SUM_BITS-1:0] total;

   assign y_round = YW'(word_in.y) + Y_ROUND;
   assign y_quot  = y_round >>> (30 - F);

   always_comb begin
      if (y_quot > S_MAX) begin
         sine_in = SW'(S_MAX);
      end else if (y_quot < S_MIN) begin
         sine_in = SW'(S_MIN);
      end else begin
         sine_in = SW'(y_quot);
      end
   end

   assign prod_in    = PW'(wave_amplitude) * PW'(sine_ff);
   assign prod_round = (PW+1)'(prod_ff) + M_ROUND;
   assign m_in       = MW'(prod_round >>> F);

   assign total = SUM_BITS'(wave_offset) + SUM_BITS'(m_ff);

   always_comb begin
      if (total > OUT_MAX) begin
         sample_in = OUT_BITS'(OUT_MAX);
         sat_in    = 1'b1;
      end else if (total < OUT_MIN) begin
         sample_in = OUT_BITS'(OUT_MIN);
         sat_in    = 1'b1;
      end else begin
         sample_in = OUT_BITS'(total);
         sat_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sine_valid_ff <= 1'b0;
         prod_valid_ff <= 1'b0;
         m_valid_ff    <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else if (advance) begin
         sine_valid_ff <= word_in.valid;
         prod_valid_ff <= sine_valid_ff;
         m_valid_ff    <= prod_valid_ff;
         out_valid_ff  <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sine_ff   <= sine_in;
         prod_ff   <= prod_in;
         m_ff      <= m_in;
         sample_ff <= sample_in;
         sat_ff    <= sat_in;
      end
   end

   assign out_valid    = out_valid_ff;
   assign sample_value = sample_ff;
   assign saturated    = sat_ff;

endmodule

// ----- sv/sine_wave_sample_generator.sv -----
`timescale 1ns / 1ps

// Sine sample generator: each word on the req channel carries a time in microseconds, and
// one word comes back on the rsp channel with offset + amplitude * sin(2 pi * phase), where
// the phase is the low PHASE_BITS bits of time_us * phase_step, saturated to signed 32 bits.
// The sine comes from a chain of 30 CORDIC cells, one rotation per cell, behind a three
// stage phase multiplier and ahead of a four stage round, scale and saturate section. The
// block takes one word every clock cycle; a stall on the rsp side holds the whole pipeline.
// The user must write registers through the csr port (0: phase_step, 1: wave_amplitude,
// 2: wave_offset) only while no word is in flight; the block does not enforce this.
module sine_wave_sample_generator
   import sws_pkg::*;
#(
   parameter int PHASE_BITS     = PHASE_BITS_DEF,
   parameter int SINE_FRAC_BITS = SINE_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,

   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [TIME_BITS-1:0]        req_time_us,

   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [OUT_BITS-1:0]  rsp_sample_value,
   output logic                        rsp_saturated,

   input  logic                        csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [CSR_DATA_BITS-1:0]    csr_wdata
);

   logic                          advance;
   logic [STEP_BITS-1:0]          phase_step_ff;
   logic signed [AMP_BITS-1:0]    amplitude_ff;
   logic signed [OFFSET_BITS-1:0] offset_ff;
   cordic_word_type               chain [CORDIC_STEPS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= '0;
         amplitude_ff  <= '0;
         offset_ff     <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_PHASE_STEP:     phase_step_ff <= csr_wdata[STEP_BITS-1:0];
            CSR_WAVE_AMPLITUDE: amplitude_ff  <= csr_wdata[AMP_BITS-1:0];
            CSR_WAVE_OFFSET:    offset_ff     <= csr_wdata[OFFSET_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   sws_phase #(
      .PHASE_BITS (PHASE_BITS)
   ) u_phase (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_valid   (req_valid),
      .time_us    (req_time_us),
      .phase_step (phase_step_ff),
      .word_out   (chain[0])
   );

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cell
      sws_cordic_cell #(
         .STAGE (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .cell_in  (chain[i]),
         .cell_out (chain[i+1])
      );
   end

   sws_scale #(
      .SINE_FRAC_BITS (SINE_FRAC_BITS)
   ) u_scale (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .word_in        (chain[CORDIC_STEPS]),
      .wave_amplitude (amplitude_ff),
      .wave_offset    (offset_ff),
      .out_valid      (rsp_valid),
      .sample_value   (rsp_sample_value),
      .saturated      (rsp_saturated)
   );

   a_sat_at_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_saturated |->
         rsp_sample_value == 32'sh7FFF_FFFF || rsp_sample_value == 32'sh8000_0000)
      else $error("saturated word not at a bound");

   a_zero_amp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && amplitude_ff == '0 |-> rsp_sample_value == offset_ff && !rsp_saturated)
      else $error("zero amplitude word differs from offset");

   a_reset_flush: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("word valid right after reset");

endmodule
